>>> sv/e2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and functions of the Euler-to-matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int CORDIC_STEPS = 17;
  localparam int ZW = 20;   // angle width in Q.16
  localparam int XW = 34;   // CORDIC x/y width in Q.30
  localparam int TW = 48;   // product term width in Q.42

  localparam logic signed [ZW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } angle_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      16:      a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

  // Round a Q.42 sum once to Q1.14 (ties up) and clamp to plus or minus one.
  function automatic logic signed [15:0] finish_q14(input logic signed [TW-1:0] acc);
    logic signed [TW-1:0] t;
    logic signed [15:0]   r;
    t = (acc + (48'sd1 <<< 27)) >>> 28;
    if (t > 48'sd16384)       r = 16'sd16384;
    else if (t < -48'sd16384) r = -16'sd16384;
    else                      r = t[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/e2r_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r channel interfaces
// Angle input channel and matrix output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface matrix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface
`default_nettype wire

>>> sv/e2r_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_front
// Accept angle items, widen to Q.16 and fold each angle into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module e2r_front import e2r_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  angle_if.sink      angles,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_ready
);

  function automatic angle_t reduce(input logic signed [15:0] a);
    angle_t r;
    logic signed [ZW-1:0] z;
    z = {a[15], a, 3'b000};
    r.neg = 1'b0;
    if (z > ANG_HALF_PI) begin
      z = z - ANG_PI;
      r.neg = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z = z + ANG_PI;
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  assign angles.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (angles.ready) begin
      item_valid <= angles.valid;
    end
    if (angles.valid && angles.ready) begin
      item.roll  <= reduce(angles.roll_angle);
      item.pitch <= reduce(angles.pitch_angle);
      item.yaw   <= reduce(angles.yaw_angle);
    end
  end

endmodule
`default_nettype wire

>>> sv/e2r_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module e2r_queue import e2r_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  input  item_t      push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output item_t      pop_item,
  input  wire logic  pop_ready
);

  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

>>> sv/e2r_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC, one step per stage, then round and clamp.
// ----------------------------------------------------------------------------
module e2r_cordic import e2r_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  angle_t           ang,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);

  logic signed [XW-1:0] xs [CORDIC_STEPS];
  logic signed [XW-1:0] ys [CORDIC_STEPS];
  logic signed [ZW-1:0] zs [CORDIC_STEPS];
  logic                 ng [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic                 ni;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = ang.z;
      assign ni = ang.neg;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign ni = ng[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ZW-1]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - atan_q16(i);
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + atan_q16(i);
        end
        ng[i] <= ni;
      end
    end
  end

  function automatic logic signed [15:0] round_clamp(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    logic signed [15:0]   r;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384)       r = 16'sd16384;
    else if (t < -34'sd16384) r = -16'sd16384;
    else                      r = t[15:0];
    return r;
  endfunction

  logic signed [15:0] cr, sr;
  assign cr = round_clamp(xs[CORDIC_STEPS-1]);
  assign sr = round_clamp(ys[CORDIC_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q14 <= ng[CORDIC_STEPS-1] ? -cr : cr;
      sin_q14 <= ng[CORDIC_STEPS-1] ? -sr : sr;
    end
  end

endmodule
`default_nettype wire

>>> sv/e2r_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2r_back
// Three CORDIC lanes, two product stages and the sum/round output register.
// ----------------------------------------------------------------------------
module e2r_back import e2r_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  input  item_t      item,
  output logic       item_ready,
  matrix_if.source   matrix
);

  localparam int LAT = CORDIC_STEPS + 3; // CORDIC steps, round, stage A, stage B

  logic               en;
  logic [LAT-1:0]     vld;
  logic signed [15:0] sr, cr, sp, cp, sy, cy;

  // The whole back pipeline advances whenever the output register frees.
  assign en         = !matrix.valid || matrix.ready;
  assign item_ready = en;

  e2r_cordic u_roll  (.clk, .en, .ang(item.roll),  .sin_q14(sr), .cos_q14(cr));
  e2r_cordic u_pitch (.clk, .en, .ang(item.pitch), .sin_q14(sp), .cos_q14(cp));
  e2r_cordic u_yaw   (.clk, .en, .ang(item.yaw),   .sin_q14(sy), .cos_q14(cy));

  // stage A: pair products
  logic signed [31:0] cycp, cysp, sycr, sysr, cycr, sycp, spsy, cysr, cpsr, cpcr;
  logic signed [15:0] a_sp, a_sr, a_cr;
  // stage B: triple products and scaled pair terms
  logic signed [TW-1:0] t01a, t01b, t02a, t02b, t11a, t11b, t12a, t12b;
  logic signed [TW-1:0] t00, t10, t20, t21, t22;

  function automatic logic signed [TW-1:0] q42(input logic signed [31:0] p);
    return {{2{p[31]}}, p, 14'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      matrix.valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[LAT-2:0], item_valid};
      matrix.valid <= vld[LAT-1];
    end
    if (en) begin
      cycp <= cy * cp;  cysp <= cy * sp;  sycr <= sy * cr;  sysr <= sy * sr;
      cycr <= cy * cr;  sycp <= sy * cp;  spsy <= sp * sy;  cysr <= cy * sr;
      cpsr <= cp * sr;  cpcr <= cp * cr;
      a_sp <= sp;  a_sr <= sr;  a_cr <= cr;

      // Widen both factors first so the triple product keeps all its bits.
      t01a <= TW'(cysp) * TW'(a_sr);  t01b <= q42(sycr);
      t02a <= q42(sysr);              t02b <= TW'(cycr) * TW'(a_sp);
      t11a <= q42(cycr);              t11b <= TW'(sysr) * TW'(a_sp);
      t12a <= TW'(spsy) * TW'(a_cr);  t12b <= q42(cysr);
      t00  <= q42(cycp);         t10  <= q42(sycp);
      t20  <= {{4{a_sp[15]}}, a_sp, 28'b0};
      t21  <= q42(cpsr);         t22  <= q42(cpcr);

      matrix.m00 <= finish_q14(t00);
      matrix.m01 <= finish_q14(t01a - t01b);
      matrix.m02 <= finish_q14(t02a + t02b);
      matrix.m10 <= finish_q14(t10);
      matrix.m11 <= finish_q14(t11a + t11b);
      matrix.m12 <= finish_q14(t12a - t12b);
      matrix.m20 <= finish_q14(-t20);
      matrix.m21 <= finish_q14(t21);
      matrix.m22 <= finish_q14(t22);
    end
  end

endmodule
`default_nettype wire

>>> sv/euler_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_unit
// Z-Y-X Euler angles to body-to-world direction cosine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   angles: valid/ready input channel, one item per roll/pitch/yaw triple,
//           each angle signed Q2.13 radians.
//   matrix: valid/ready output channel, one item with the nine entries,
//           signed Q1.14, clamped to plus or minus one.
// Throughput: one item per cycle while the receiver takes results. Each angle
//   runs through its own 17-stage CORDIC pipeline, followed by two multiply stages and a sum/round register.
// Path: with no stall, an accepted item passes the front register, which
//   loads at the accepting edge, then the queue, 17 CORDIC steps and a
//   rounding register, two product stages and the sum/round register.
// Stalls: when the receiver holds ready low, the back pipeline freezes with
//   its result held on the outputs; the front keeps taking items until the
//   two-entry queue and the front register fill, then drops angles.ready.
// Reset: synchronous, active high; clears all valid bits and the queue.
//   No state is kept between items.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_unit import e2r_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  angle_if.sink     angles,
  matrix_if.source  matrix
);

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  // Front: take items and fold angles into the CORDIC range.
  e2r_front u_front (
    .clk, .rst, .angles,
    .item_valid(f_valid), .item(f_item), .item_ready(f_ready)
  );

  // Queue: decouple the front from a stalled back.
  e2r_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_item(f_item), .push_ready(f_ready),
    .pop_valid(q_valid),  .pop_item(q_item),  .pop_ready(q_ready)
  );

  // Back: sine/cosine, products, round and hold the result.
  e2r_back u_back (
    .clk, .rst,
    .item_valid(q_valid), .item(q_item), .item_ready(q_ready),
    .matrix
  );

`ifndef SYNTHESIS
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !matrix.valid) else $error("output valid after reset");

  a_entry_saturated: assert property (@(posedge clk) disable iff (rst)
    matrix.valid |-> (matrix.m22 <= 16'sd16384 && matrix.m22 >= -16'sd16384 &&
                      matrix.m01 <= 16'sd16384 && matrix.m01 >= -16'sd16384))
    else $error("matrix entry outside unit range");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (!matrix.valid || matrix.ready))
    else $error("queue popped while back pipeline stalled");
`endif

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler-to-matrix unit testbench
// Drives random and corner angle triples through the valid/ready channels,
// predicts each rotation matrix with a CORDIC sine/cosine model and checks
// every entry in order, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import e2r_pkg::*;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  // Scoreboard: predicts the matrix of each accepted angle triple and
  // matches results against the oldest prediction.
  class matrix_scoreboard;
    matrix_t pending[$];
    int errors = 0;
    int checked = 0;

    static function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint unit_clamp(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    static function void sine_cosine(logic signed [15:0] ang,
                                     output longint sn, output longint cs);
      longint z, x, y, nx, ny;
      longint atan_q[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
      bit flip;
      z = longint'(ang) * 8;
      flip = 0;
      x = 652032874;
      y = 0;
      if (z > 102944) begin
        z -= 205887; flip = 1;
      end else if (z < -102944) begin
        z += 205887; flip = 1;
      end
      for (int i = 0; i < 17; i++) begin
        if (z >= 0) begin
          nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atan_q[i];
        end else begin
          nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atan_q[i];
        end
        x = nx; y = ny;
      end
      x = unit_clamp(floor_shift(x + 32768, 16));
      y = unit_clamp(floor_shift(y + 32768, 16));
      if (flip) begin
        x = -x; y = -y;
      end
      cs = x; sn = y;
    endfunction

    static function logic signed [15:0] round_entry(longint acc);
      return 16'(unit_clamp(floor_shift(acc + (longint'(1) << 27), 28)));
    endfunction

    function void note_angles(logic signed [15:0] r, p, yw);
      longint sr, cr, sp, cp, sy, cy;
      longint k;
      matrix_t e;
      k = 16384;
      sine_cosine(r, sr, cr);
      sine_cosine(p, sp, cp);
      sine_cosine(yw, sy, cy);
      e.m[0] = round_entry(cy * cp * k);
      e.m[1] = round_entry(cy * sp * sr - sy * cr * k);
      e.m[2] = round_entry(sy * sr * k + cy * cr * sp);
      e.m[3] = round_entry(sy * cp * k);
      e.m[4] = round_entry(cy * cr * k + sy * sr * sp);
      e.m[5] = round_entry(sp * sy * cr - cy * sr * k);
      e.m[6] = round_entry(-sp * k * k);
      e.m[7] = round_entry(cp * sr * k);
      e.m[8] = round_entry(cp * cr * k);
      pending.push_back(e);
    endfunction

    function void check_matrix(matrix_t got);
      string names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                          "m20", "m21", "m22"};
      matrix_t e;
      if (pending.size() == 0) begin
        $error("matrix item with no prediction waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== e.m[i]) begin
          $error("%s: expected %0d, actual %0d", names[i], e.m[i], got.m[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  angle_if  angles ();
  matrix_if matrix ();

  euler_to_rotation_matrix_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .angles (angles.sink),
    .matrix (matrix.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  matrix_scoreboard board = new();

  // Idle percentages for the sender and the receiver, changed per phase.
  int send_idle = 0;
  int recv_stall = 0;
  int sent = 0;

  // Receiver: stall at random, check every accepted matrix item.
  initial begin
    matrix.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && matrix.valid && matrix.ready) begin
        matrix_t got;
        got.m = '{matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
                  matrix.m12, matrix.m20, matrix.m21, matrix.m22};
        board.check_matrix(got);
      end
      matrix.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Send one triple: hold valid until accepted, with optional idle gaps first.
  task automatic send_angles(logic signed [15:0] r, p, yw);
    while ($urandom_range(99) < send_idle) begin
      angles.valid <= 0;
      @(posedge clk);
    end
    angles.valid       <= 1;
    angles.roll_angle  <= r;
    angles.pitch_angle <= p;
    angles.yaw_angle   <= yw;
    @(posedge clk);
    while (!angles.ready) @(posedge clk);
    board.note_angles(r, p, yw);
    sent++;
  endtask

  // Drop valid and hold until every prediction has been matched.
  task automatic drain_results();
    angles.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Angles near the reduction boundaries, the wrap point and the extremes.
  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] edges[8] = '{16'sh7fff, -16'sh8000, 16'sd12868, 16'sd12869,
                                     -16'sd12868, -16'sd12869, 16'sd25736, 16'sd0};
    if ($urandom_range(9) == 0)
      return edges[$urandom_range(7)] + 16'($signed($urandom_range(4)) - 2);
    return 16'($urandom);
  endfunction

  initial begin
    logic signed [15:0] corner[10] = '{16'sd0, 16'sh7fff, -16'sh8000, 16'sd12868,
                                       16'sd12869, -16'sd12868, -16'sd12869,
                                       16'sd25736, -16'sd25736, 16'sh5555};
    int total;
    angles.valid       = 0;
    angles.roll_angle  = 0;
    angles.pitch_angle = 0;
    angles.yaw_angle   = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: each corner angle on each axis, then all extremes together.
    for (int i = 0; i < 10; i++) begin
      send_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]);
      if (i % 4 == 0) send_angles(corner[i], corner[i], corner[i]);
    end
    send_angles(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_angles(-16'sh8000, 16'sh7fff, -16'sh8000);
    // Pause the sender until the pipe is empty.
    drain_results();

    // Random phases: free flow, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      total = 325;
      for (int n = 0; n < total; n++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    drain_results();
    // Catch any stray extra item after the last expected one.
    repeat (40) @(posedge clk);

    $display("Sent %0d angle triples, checked %0d matrices over four idling phases.",
             sent, board.checked);
    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
